// ===== hw/rtl/tcce_pkg.sv =====
package tcce_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
	localparam int ADDR_W         = $clog2(CELL_COUNT);
	localparam int IDX_W          = 12;
	localparam int CELL_W         = 16;

	localparam logic [CELL_W-1:0] BLANK_SCROLL = 16'h0720;
	localparam logic [CELL_W-1:0] BLANK_CLEAR  = 16'h0700;
	localparam logic [7:0]        DEFAULT_ATTR = 8'h07;
	localparam logic [7:0]        TAB_MASK     = 8'hF8;
	localparam logic [7:0]        TAB_STEP     = 8'd8;

	localparam logic [ADDR_W-1:0] LAST_CELL    = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] BOTTOM_FIRST = ADDR_W'(CELL_COUNT - SCREEN_COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP     = ADDR_W'(SCREEN_COLUMNS);

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic clear;
		logic scroll;
	} mv_cmd_t;

	function automatic logic [IDX_W-1:0] cell_index(input logic [4:0] y, input logic [6:0] x);
		logic [IDX_W-1:0] row_base;
		row_base = IDX_W'(32'(y) * SCREEN_COLUMNS);
		return row_base + IDX_W'(x);
	endfunction

endpackage

// ===== hw/rtl/tcce_ram.sv =====
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/tcce_cursor.sv =====
module tcce_cursor
	import tcce_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         put_en,
	input  logic         clear_en,
	input  logic [7:0]   char_code,
	input  logic [7:0]   attr_in,
	output logic [6:0]   cur_x,
	output logic [4:0]   cur_y,
	output logic         need_scroll,
	output mem_req_t     wr_req
);

	logic [6:0] cur_x_q;
	logic [4:0] cur_y_q;
	logic [7:0] nx;
	logic [5:0] ny;
	logic [7:0] x_w;
	logic [5:0] y_w;
	logic       do_write;
	logic [7:0] attr;

	always_comb begin
		attr     = (attr_in == 8'd0) ? DEFAULT_ATTR : attr_in;
		x_w      = {1'b0, cur_x_q};
		y_w      = {1'b0, cur_y_q};
		do_write = 1'b0;
		case (char_code)
			CH_BS: begin
				if (cur_x_q != 7'd0) begin
					x_w = x_w - 8'd1;
				end
			end
			CH_TAB: begin
				x_w = (x_w + TAB_STEP) & TAB_MASK;
			end
			CH_CR: begin
				x_w = 8'd0;
			end
			CH_LF: begin
				x_w = 8'd0;
				y_w = y_w + 6'd1;
			end
			default: begin
				if (char_code >= CH_SPACE) begin
					do_write = 1'b1;
					x_w      = x_w + 8'd1;
				end
			end
		endcase
		nx = x_w;
		ny = y_w;
		if (x_w >= 8'(SCREEN_COLUMNS)) begin
			nx = 8'd0;
			ny = y_w + 6'd1;
		end
		need_scroll = put_en && (ny >= 6'(SCREEN_ROWS));
	end

	always_comb begin
		wr_req       = '0;
		wr_req.we    = put_en && do_write;
		wr_req.waddr = ADDR_W'(cell_index(cur_y_q, cur_x_q));
		wr_req.wdata = {attr, char_code};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= 7'd0;
			cur_y_q <= 5'd0;
		end else if (clear_en) begin
			cur_x_q <= 7'd0;
			cur_y_q <= 5'd0;
		end else if (put_en) begin
			cur_x_q <= nx[6:0];
			cur_y_q <= (ny >= 6'(SCREEN_ROWS)) ? 5'(SCREEN_ROWS - 1) : ny[4:0];
		end
	end

	assign cur_x = cur_x_q;
	assign cur_y = cur_y_q;

endmodule

// ===== hw/rtl/tcce_mover.sv =====
module tcce_mover
	import tcce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  mv_cmd_t           cmd,
	input  logic [CELL_W-1:0] rdata,
	output mem_req_t          req,
	output logic              done
);

	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_CLEAR = 4'b0010,
		M_COPY  = 4'b0100,
		M_FILL  = 4'b1000
	} mv_state_t;

	mv_state_t         state_q;
	logic [ADDR_W-1:0] ptr_q;
	logic              rd_end_q;
	logic              cp_vld_s1;
	logic [ADDR_W-1:0] waddr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= M_CLEAR;
			ptr_q     <= '0;
			rd_end_q  <= 1'b0;
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == M_COPY) && !rd_end_q;
			unique case (state_q)
				M_IDLE: begin
					if (cmd.clear) begin
						state_q <= M_CLEAR;
						ptr_q   <= '0;
					end else if (cmd.scroll) begin
						state_q  <= M_COPY;
						ptr_q    <= ROW_STEP;
						rd_end_q <= 1'b0;
					end
				end
				M_CLEAR, M_FILL: begin
					if (ptr_q == LAST_CELL) begin
						state_q <= M_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				M_COPY: begin
					if (!rd_end_q) begin
						if (ptr_q == LAST_CELL) begin
							rd_end_q <= 1'b1;
						end else begin
							ptr_q <= ptr_q + 1'b1;
						end
					end else if (!cp_vld_s1) begin
						state_q <= M_FILL;
						ptr_q   <= BOTTOM_FIRST;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ptr_q - ROW_STEP;
	end

	always_comb begin
		req  = '0;
		done = 1'b0;
		unique case (state_q)
			M_CLEAR: begin
				req.we    = 1'b1;
				req.waddr = ptr_q;
				req.wdata = BLANK_CLEAR;
				done      = (ptr_q == LAST_CELL);
			end
			M_COPY: begin
				req.re    = !rd_end_q;
				req.raddr = ptr_q;
				req.we    = cp_vld_s1;
				req.waddr = waddr_s1;
				req.wdata = rdata;
			end
			M_FILL: begin
				req.we    = 1'b1;
				req.waddr = ptr_q;
				req.wdata = BLANK_SCROLL;
				done      = (ptr_q == LAST_CELL);
			end
			default: begin
				req = '0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/text_console_char_engine_core.sv =====
// A put without scroll, a read or an unused action moves S_IDLE to S_DONE; out_valid is then
// registered from S_DONE once the output register is free. A put that scrolls runs a row copy
// through the cell RAM read/write ports, then a one-row fill; clear uses one cell write per cycle.
// Requests are taken one at a time (accept, then load result).
// Reset: cursor homes and a clearing pass writes 0x0700 to every cell;
// in_stall stays high until it ends.
module text_console_char_engine_core
	import tcce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attr_in,
	input  logic [10:0] cell_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic [10:0] cursor_index,
	output logic [15:0] read_data
);

	typedef enum logic [3:0] {
		S_INIT = 4'b0001,
		S_IDLE = 4'b0010,
		S_BUSY = 4'b0100,
		S_DONE = 4'b1000
	} top_state_t;

	top_state_t        state_q;
	logic              out_valid_q;
	logic              rd_hit_q;
	logic              accept;
	logic              in_range;
	logic              put_en;
	logic              clear_en;
	logic              need_scroll;
	logic              mv_done;
	logic              load_out;
	logic [6:0]        cur_x;
	logic [4:0]        cur_y;
	logic [CELL_W-1:0] ram_rdata;
	mv_cmd_t           mv_cmd;
	mem_req_t          mv_req;
	mem_req_t          put_req;
	mem_req_t          ram_req;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign put_en   = accept && (action == ACT_PUT);
	assign clear_en = accept && (action == ACT_CLEAR);
	assign in_range = ({1'b0, cell_address} < IDX_W'(CELL_COUNT));
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign mv_cmd.clear  = clear_en;
	assign mv_cmd.scroll = need_scroll;

	tcce_cursor u_cursor (
		.clk         (clk),
		.arst_n      (arst_n),
		.put_en      (put_en),
		.clear_en    (clear_en),
		.char_code   (char_code),
		.attr_in     (attr_in),
		.cur_x       (cur_x),
		.cur_y       (cur_y),
		.need_scroll (need_scroll),
		.wr_req      (put_req)
	);

	tcce_mover u_mover (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mv_cmd),
		.rdata  (ram_rdata),
		.req    (mv_req),
		.done   (mv_done)
	);

	always_comb begin
		ram_req = mv_req;
		if (state_q == S_IDLE) begin
			ram_req.we    = put_req.we;
			ram_req.waddr = put_req.waddr;
			ram_req.wdata = put_req.wdata;
			ram_req.re    = accept && (action == ACT_READ) && in_range;
			ram_req.raddr = ADDR_W'(cell_address);
		end
	end

	tcce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			out_valid_q <= 1'b0;
			rd_hit_q    <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (mv_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						rd_hit_q <= (action == ACT_READ) && in_range;
						if (clear_en || need_scroll) begin
							state_q <= S_BUSY;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_BUSY: begin
					if (mv_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the result payload while stalled
	always_ff @(posedge clk) begin
		if (load_out) begin
			cursor_col   <= cur_x;
			cursor_row   <= cur_y;
			cursor_index <= 11'(cell_index(cur_y, cur_x));
			read_data    <= rd_hit_q ? ram_rdata : 16'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
